@@ rtl/escape_byte_unstuffing_deframer_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the escape byte unstuffing deframer
// Shared concurrent assertion forms used by the checker.
// ---------------------------------------------------------------------------
`ifndef ESCAPE_BYTE_UNSTUFFING_DEFRAMER_UNIT_MACROS_SVH
`define ESCAPE_BYTE_UNSTUFFING_DEFRAMER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EBUD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define EBUD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

@@ rtl/ebud_pkg.sv @@
// ---------------------------------------------------------------------------
// Escape byte unstuffing deframer package
// Types, codes and constants shared by the deframer files.
// ---------------------------------------------------------------------------
package ebud_pkg;

  localparam int unsigned FRAME_LIMIT_DEF = 64;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] ESC_CODE = 8'd10;
  localparam logic [BYTE_W-1:0] ESC_ALT  = 8'd11;
  localparam logic [BYTE_W-1:0] CR_CODE  = 8'd13;
  localparam logic [LEN_W-1:0]  PAYLOAD_CAP = 7'd64;

  localparam logic [BYTE_W-1:0] STOP_BYTE_RST   = 8'd13;
  localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 7'd64;
  localparam logic              LINK_ENABLE_RST = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } out_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STOP_BYTE   = 2'd0,
    REG_MAX_PAYLOAD = 2'd1,
    REG_LINK_ENABLE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    out_kind_e         out_kind;
    logic [LEN_W-1:0]  frame_length;
  } result_t;

endpackage

@@ rtl/ebud_ifs.sv @@
// ---------------------------------------------------------------------------
// Escape byte unstuffing deframer channels
// Valid/ready channels for raw link bytes and decoded results.
// ---------------------------------------------------------------------------
interface ebud_rx_if;
  logic                        valid;
  logic                        ready;
  logic [ebud_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ebud_res_if;
  logic                        valid;
  logic                        ready;
  logic [ebud_pkg::BYTE_W-1:0] out_byte;
  ebud_pkg::out_kind_e         out_kind;
  logic [ebud_pkg::LEN_W-1:0]  frame_length;

  modport source (output valid, output out_byte, output out_kind, output frame_length,
                  input ready);
  modport sink   (input valid, input out_byte, input out_kind, input frame_length,
                  output ready);
endinterface

@@ rtl/escape_byte_unstuffing_deframer_unit.sv @@
// ---------------------------------------------------------------------------
// Escape byte unstuffing deframer
// Decodes escaped link bytes into payload bytes and reports frame ends and
// escape errors with the decoded frame length.
// ---------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  rx_i     in         rx_byte
//  res_o    out        out_byte, out_kind, frame_length
//  cfg      in         cfg_we_i, cfg_idx_i, cfg_wdata_i (write only)
//
// One raw byte is taken every cycle; its result is registered and, unless
// res_o stalls, appears in the cycle after acceptance. A two-entry output
// buffer keeps rx_i ready while one result is stalled; rx_i stalls only
// when both are full. Reset clears frame state and loads register defaults.
// ---------------------------------------------------------------------------
module escape_byte_unstuffing_deframer_unit #(
  parameter int unsigned FRAME_LIMIT = ebud_pkg::FRAME_LIMIT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ebud_rx_if.sink                        rx_i,
  ebud_res_if.source                     res_o,
  input  logic                           cfg_we_i,
  input  logic [ebud_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ebud_pkg::BYTE_W-1:0]    cfg_wdata_i
);
  import ebud_pkg::*;

  localparam int unsigned RAW_W = $clog2(FRAME_LIMIT);
  localparam logic [RAW_W-1:0] RAW_LAST = RAW_W'(FRAME_LIMIT - 1);

  logic [BYTE_W-1:0] stop_byte_q;
  logic [LEN_W-1:0]  max_payload_q;
  logic              link_enable_q;

  logic              esc_q, esc_d;
  logic              disc_q, disc_d;
  logic [LEN_W-1:0]  dec_q, dec_d;
  logic [RAW_W-1:0]  raw_q, raw_d;

  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;
  logic              skid_valid_q, skid_valid_d;
  result_t           skid_q, skid_d;

  logic              accept;
  logic              is_stop;
  logic              limit_hit;
  logic [LEN_W-1:0]  limit;
  logic              res_valid;
  result_t           res;
  logic              out_free;

  assign rx_i.ready         = !skid_valid_q;
  assign res_o.valid        = out_valid_q;
  assign res_o.out_byte     = out_q.out_byte;
  assign res_o.out_kind     = out_q.out_kind;
  assign res_o.frame_length = out_q.frame_length;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_byte_q   <= STOP_BYTE_RST;
      max_payload_q <= MAX_PAYLOAD_RST;
      link_enable_q <= LINK_ENABLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STOP_BYTE:   stop_byte_q   <= cfg_wdata_i;
        REG_MAX_PAYLOAD: max_payload_q <= cfg_wdata_i[LEN_W-1:0];
        REG_LINK_ENABLE: link_enable_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    accept    = rx_i.valid && !skid_valid_q && link_enable_q;
    is_stop   = rx_i.rx_byte == stop_byte_q;
    limit_hit = !is_stop && (raw_q == RAW_LAST);
    limit     = (max_payload_q > PAYLOAD_CAP) ? PAYLOAD_CAP : max_payload_q;

    esc_d     = esc_q;
    disc_d    = disc_q;
    dec_d     = dec_q;
    raw_d     = raw_q;
    res_valid = 1'b0;
    res       = '{out_byte: '0, out_kind: KIND_DATA, frame_length: '0};

    if (accept) begin
      if (!is_stop) begin
        raw_d = raw_q + RAW_W'(1);
      end
      if (is_stop || limit_hit) begin
        esc_d     = 1'b0;
        disc_d    = 1'b0;
        dec_d     = '0;
        raw_d     = '0;
        res_valid = !disc_q;
        res.out_kind     = KIND_END;
        res.frame_length = dec_q;
      end else if (!disc_q && (dec_q < limit)) begin
        if (esc_q) begin
          esc_d = 1'b0;
          if (rx_i.rx_byte == ESC_CODE || rx_i.rx_byte == ESC_ALT) begin
            res_valid    = 1'b1;
            res.out_byte = (rx_i.rx_byte == ESC_CODE) ? ESC_CODE : CR_CODE;
            dec_d        = dec_q + LEN_W'(1);
          end else begin
            disc_d           = 1'b1;
            res_valid        = 1'b1;
            res.out_kind     = KIND_ERROR;
            res.frame_length = dec_q;
          end
        end else if (rx_i.rx_byte == ESC_CODE) begin
          esc_d = 1'b1;
        end else if (rx_i.rx_byte == CR_CODE) begin
          disc_d           = 1'b1;
          dec_d            = '0;
          res_valid        = 1'b1;
          res.out_kind     = KIND_END;
          res.frame_length = dec_q;
        end else begin
          res_valid    = 1'b1;
          res.out_byte = rx_i.rx_byte;
          dec_d        = dec_q + LEN_W'(1);
        end
      end
    end

    out_free     = !out_valid_q || res_o.ready;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = res_valid;
        out_d       = res;
      end
    end else if (res_valid) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q        <= 1'b0;
      disc_q       <= 1'b0;
      dec_q        <= '0;
      raw_q        <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      esc_q        <= esc_d;
      disc_q       <= disc_d;
      dec_q        <= dec_d;
      raw_q        <= raw_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

@@ rtl/ebud_checker.sv @@
// ---------------------------------------------------------------------------
// Escape byte unstuffing deframer checker
// Port-level properties of the deframer result channel.
// ---------------------------------------------------------------------------
`include "escape_byte_unstuffing_deframer_unit_macros.svh"

module ebud_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [ebud_pkg::BYTE_W-1:0] out_byte_i,
  input logic [1:0]                  out_kind_i,
  input logic [ebud_pkg::LEN_W-1:0]  frame_length_i
);
  import ebud_pkg::*;

  `EBUD_ASSERT_SAME(a_data_len_zero, clk_i, rst_ni, out_valid_i && out_kind_i == KIND_DATA, frame_length_i == '0)
  `EBUD_ASSERT_SAME(a_ctrl_byte_zero, clk_i, rst_ni, out_valid_i && out_kind_i != KIND_DATA, out_byte_i == '0)
  `EBUD_ASSERT_SAME(a_len_cap, clk_i, rst_ni, out_valid_i, frame_length_i <= PAYLOAD_CAP)
  `EBUD_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_byte_i) && $stable(out_kind_i) && $stable(frame_length_i))

endmodule

bind escape_byte_unstuffing_deframer_unit ebud_checker u_ebud_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .out_byte_i     (res_o.out_byte),
  .out_kind_i     (res_o.out_kind),
  .frame_length_i (res_o.frame_length)
);
